// ===== sv/mts_pkg.sv =====
// Shared types, request codes and reset constants of the melody tone sequencer.
package mts_pkg;

    localparam int REQ_W = 3;
    localparam int IDX_IN_W = 8;
    localparam int LEN_W = 15;
    localparam int DIV_W = 16;
    localparam int NOTE_W = LEN_W + DIV_W;

    localparam int NOTE_DEPTH_DEF = 256;

    localparam logic [REQ_W-1:0] REQ_TICK  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PLAY  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_STOP  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_WRITE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TONE  = 3'd4;

    localparam logic [DIV_W-1:0] RELOAD_RST  = 16'd1000;
    localparam logic [LEN_W-1:0] COMPARE_RST = 15'd500;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [IDX_IN_W-1:0] note_index;
        logic [LEN_W-1:0]    note_length;
        logic [DIV_W-1:0]    note_divider;
    } t_req;

    typedef struct packed {
        logic             tone_on;
        logic [DIV_W-1:0] period;
        logic [LEN_W-1:0] high_time;
        logic             melody_active;
    } t_res;

endpackage

// ===== sv/mts_req_if.sv =====
// Request channel: valid/ready handshake carrying one request beat.
interface mts_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [7:0]  note_index;
    logic [14:0] note_length;
    logic [15:0] note_divider;

    modport source (output valid, output req_type, output note_index,
                    output note_length, output note_divider, input ready);
    modport sink (input valid, input req_type, input note_index,
                  input note_length, input note_divider, output ready);
endinterface

// ===== sv/mts_res_if.sv =====
// Result channel: valid/ready handshake carrying one tone status beat.
interface mts_res_if;
    logic        valid;
    logic        ready;
    logic        tone_on;
    logic [15:0] period;
    logic [14:0] high_time;
    logic        melody_active;

    modport source (output valid, output tone_on, output period,
                    output high_time, output melody_active, input ready);
    modport sink (input valid, input tone_on, input period,
                  input high_time, input melody_active, output ready);
endinterface

// ===== sv/mts_ram.sv =====
// Generic single-port RAM with registered read data.
module mts_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/mts_seq.sv =====
// Melody sequencer: request decode, note counters and note memory fetch.
module mts_seq #(
    parameter int NOTE_DEPTH = mts_pkg::NOTE_DEPTH_DEF,
    localparam int IDX_W = $clog2(NOTE_DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_v,
    input  mts_pkg::t_req              i_req,
    output logic                       o_busy,
    output logic                       o_res_v,
    output mts_pkg::t_res              o_res,
    output logic                       o_ram_en,
    output logic                       o_ram_we,
    output logic [IDX_W-1:0]           o_ram_addr,
    output logic [mts_pkg::NOTE_W-1:0] o_ram_wdata,
    input  logic [mts_pkg::NOTE_W-1:0] i_ram_rdata
);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_FETCH = 1'b1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NOTE_DEPTH - 1);

    logic                         r_state, n_state;
    logic [IDX_W-1:0]             r_cur, n_cur;
    logic [IDX_W-1:0]             r_start, n_start;
    logic [mts_pkg::LEN_W-1:0]    r_ticks, n_ticks;
    logic                         r_pend, n_pend;
    logic                         r_en, n_en;
    logic [mts_pkg::DIV_W-1:0]    r_reload, n_reload;
    logic [mts_pkg::LEN_W-1:0]    r_compare, n_compare;

    logic [IDX_W-1:0]             idx;
    logic [IDX_W-1:0]             nxt_idx;
    logic [mts_pkg::LEN_W-1:0]    rd_len;
    logic [mts_pkg::DIV_W-1:0]    rd_div;

    if (NOTE_DEPTH >= 256) begin : g_no_wrap
        assign idx = IDX_W'(i_req.note_index);
    end else begin : g_wrap
        // Wrap the request index by reciprocal multiplication: quotient, then remainder.
        localparam int RECIP_SHIFT = 16;
        localparam int RECIP = ((1 << RECIP_SHIFT) + NOTE_DEPTH - 1) / NOTE_DEPTH;

        logic [23:0]                   q_prod;
        logic [mts_pkg::IDX_IN_W-1:0]  q_est;
        logic [15:0]                   q_back;
        logic [mts_pkg::IDX_IN_W-1:0]  idx_rem;

        assign q_prod  = 24'(i_req.note_index) * 24'(RECIP);
        assign q_est   = q_prod[23:16];
        assign q_back  = 16'(q_est) * 16'(NOTE_DEPTH);
        assign idx_rem = i_req.note_index - q_back[mts_pkg::IDX_IN_W-1:0];
        assign idx     = IDX_W'(idx_rem);
    end

    assign nxt_idx = (r_cur == LAST_IDX) ? '0 : r_cur + 1'b1;
    assign rd_len  = i_ram_rdata[mts_pkg::NOTE_W-1 -: mts_pkg::LEN_W];
    assign rd_div  = i_ram_rdata[mts_pkg::DIV_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_start     = r_start;
        n_ticks     = r_ticks;
        n_pend      = r_pend;
        n_en        = r_en;
        n_reload    = r_reload;
        n_compare   = r_compare;
        o_ram_en    = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_addr  = idx;
        o_ram_wdata = {i_req.note_length, i_req.note_divider};
        o_res_v     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req_v) begin
                    o_res_v = 1'b1;
                    case (i_req.req_type)
                        mts_pkg::REQ_TICK: begin
                            if (r_pend) begin
                                // pending start wins: fetch the first note
                                n_pend     = 1'b0;
                                n_cur      = r_start;
                                o_ram_addr = r_start;
                                o_ram_en   = 1'b1;
                                n_state    = S_FETCH;
                                o_res_v    = 1'b0;
                            end else if (r_ticks != '0) begin
                                n_ticks = r_ticks - 1'b1;
                                if (r_ticks == mts_pkg::LEN_W'(1)) begin
                                    n_cur      = nxt_idx;
                                    o_ram_addr = nxt_idx;
                                    o_ram_en   = 1'b1;
                                    n_state    = S_FETCH;
                                    o_res_v    = 1'b0;
                                end
                            end
                        end
                        mts_pkg::REQ_PLAY: begin
                            n_start = idx;
                            n_pend  = 1'b1;
                        end
                        mts_pkg::REQ_STOP: begin
                            n_ticks = '0;
                            n_pend  = 1'b0;
                            n_en    = 1'b0;
                        end
                        mts_pkg::REQ_WRITE: begin
                            o_ram_en = 1'b1;
                            o_ram_we = 1'b1;
                        end
                        mts_pkg::REQ_TONE: begin
                            n_reload  = i_req.note_divider;
                            n_compare = i_req.note_divider[mts_pkg::DIV_W-1:1];
                            n_en      = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FETCH: begin
                o_res_v = 1'b1;
                n_state = S_IDLE;
                n_ticks = rd_len;
                if (rd_len == '0 || rd_div == '0) begin
                    // melody end or rest: silence the output
                    n_en = 1'b0;
                end else begin
                    n_reload  = rd_div;
                    n_compare = rd_div[mts_pkg::DIV_W-1:1];
                    n_en      = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur     <= '0;
            r_start   <= '0;
            r_ticks   <= '0;
            r_pend    <= 1'b0;
            r_en      <= 1'b0;
            r_reload  <= mts_pkg::RELOAD_RST;
            r_compare <= mts_pkg::COMPARE_RST;
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_start   <= n_start;
            r_ticks   <= n_ticks;
            r_pend    <= n_pend;
            r_en      <= n_en;
            r_reload  <= n_reload;
            r_compare <= n_compare;
        end
    end

    assign o_busy = (r_state == S_FETCH);

    always_comb begin
        o_res.tone_on       = n_en;
        o_res.period        = n_reload;
        o_res.high_time     = n_compare;
        o_res.melody_active = n_pend || (n_ticks != '0);
    end

    a_fetch_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FETCH |=> r_state == S_IDLE)
        else $error("fetch state held longer than one cycle");

    a_pending_fetches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_req_v && i_req.req_type == mts_pkg::REQ_TICK && r_pend)
        |=> (r_state == S_FETCH && !r_pend))
        else $error("tick with pending start did not fetch the first note");

    a_no_write_in_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FETCH |-> !o_ram_we)
        else $error("note memory written during a fetch");

    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_req_v && !o_res_v) |=> o_res_v)
        else $error("deferred result not produced after fetch");

endmodule

// ===== sv/melody_tone_sequencer_core.sv =====
// Melody tone sequencer: requests run one at a time; a tick that moves to a new note first
// reads the note memory (registered read), then loads the counters and tone in a fetch
// state, and ready stays low meanwhile. The result of each request is the
// tone status after it; an output register plus a one-beat hold stage let one more
// request enter while a result waits. The note memory has no reset and is not cleared:
// play only notes that were written.
module melody_tone_sequencer_core #(
    parameter int NOTE_DEPTH = mts_pkg::NOTE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mts_req_if.sink   i_req,
    mts_res_if.source o_res
);

    localparam int IDX_W = $clog2(NOTE_DEPTH);

    mts_pkg::t_req             req;
    mts_pkg::t_res             res;
    logic                      res_v;
    logic                      busy;
    logic                      accept;
    logic                      ram_en;
    logic                      ram_we;
    logic [IDX_W-1:0]          ram_addr;
    logic [mts_pkg::NOTE_W-1:0] ram_wdata;
    logic [mts_pkg::NOTE_W-1:0] ram_rdata;

    logic          r_out_v, n_out_v;
    logic          r_hold_v, n_hold_v;
    mts_pkg::t_res r_out, n_out;
    mts_pkg::t_res r_hold, n_hold;

    assign req.req_type     = i_req.req_type;
    assign req.note_index   = i_req.note_index;
    assign req.note_length  = i_req.note_length;
    assign req.note_divider = i_req.note_divider;

    assign i_req.ready = !busy && !r_hold_v;
    assign accept      = i_req.valid && i_req.ready;

    mts_seq #(.NOTE_DEPTH(NOTE_DEPTH)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_v     (accept),
        .i_req       (req),
        .o_busy      (busy),
        .o_res_v     (res_v),
        .o_res       (res),
        .o_ram_en    (ram_en),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata)
    );

    mts_ram #(.WIDTH(mts_pkg::NOTE_W), .DEPTH(NOTE_DEPTH)) u_note_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Output register with a one-beat hold behind it.
    always_comb begin
        n_out_v  = r_out_v;
        n_hold_v = r_hold_v;
        n_out    = r_out;
        n_hold   = r_hold;
        if (!r_out_v || o_res.ready) begin
            if (r_hold_v) begin
                n_out    = r_hold;
                n_out_v  = 1'b1;
                n_hold_v = 1'b0;
            end else if (res_v) begin
                n_out   = res;
                n_out_v = 1'b1;
            end else begin
                n_out_v = 1'b0;
            end
        end else if (res_v) begin
            n_hold   = res;
            n_hold_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_hold_v <= n_hold_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_hold <= n_hold;
    end

    assign o_res.valid         = r_out_v;
    assign o_res.tone_on       = r_out.tone_on;
    assign o_res.period        = r_out.period;
    assign o_res.high_time     = r_out.high_time;
    assign o_res.melody_active = r_out.melody_active;

    a_hold_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_v |-> r_out_v)
        else $error("hold stage full while output register empty");

    a_no_result_into_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(res_v && r_hold_v))
        else $error("result produced while hold stage full");

    a_fetch_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && !$past(busy)) |-> $past(accept))
        else $error("note fetch started without an accepted request");

endmodule
